/* hdl/gil_pkg.sv */
`timescale 1ns / 1ps
package gil_pkg;

   localparam int MAX_DIM  = 1024;
   localparam int DIM_W    = 11;
   localparam int COORD_W  = 10;
   localparam int IDX_W    = 32;
   localparam int NXY_W    = 21;
   localparam int NXYZ_W   = 31;

   localparam logic       FUNC_FLATTEN = 1'b0;
   localparam logic       FUNC_SPLIT   = 1'b1;
   localparam logic [1:0] COMP_BAD     = 2'd3;

   localparam logic [1:0] CSR_SIZE_X = 2'd0;
   localparam logic [1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [1:0] CSR_SIZE_Z = 2'd2;

   typedef struct packed {
      logic               func;
      logic [COORD_W-1:0] coord_i;
      logic [COORD_W-1:0] coord_j;
      logic [COORD_W-1:0] coord_k;
      logic [1:0]         comp_d;
      logic [IDX_W-1:0]   linear_index;
   } gil_req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   linear_out;
      logic [COORD_W-1:0] out_i;
      logic [COORD_W-1:0] out_j;
      logic [COORD_W-1:0] out_k;
      logic [1:0]         out_d;
      logic               range_error;
   } gil_rsp_type;

   // grid sizes and derived plane / volume sizes
   typedef struct packed {
      logic [DIM_W-1:0]  nx;
      logic [DIM_W-1:0]  ny;
      logic [DIM_W-1:0]  nz;
      logic [NXY_W-1:0]  nxy;
      logic [NXYZ_W-1:0] nxyz;
      logic [IDX_W-1:0]  nxyz2;
      logic [IDX_W:0]    nxyz3;
   } gil_geom_type;

   // classified item between front and back
   typedef struct packed {
      logic               func;
      logic               err;
      logic [COORD_W-1:0] i;
      logic [COORD_W-1:0] j;
      logic [COORD_W-1:0] k;
      logic [1:0]         d;
      logic [IDX_W-1:0]   idx;
   } gil_item_type;

   function automatic logic [DIM_W-1:0] gil_clamp(input logic [DIM_W-1:0] s);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(MAX_DIM);
      return (s > lim) ? lim : s;
   endfunction

endpackage

/* hdl/grid_index_linearizer_top.sv */
`timescale 1ns / 1ps
// channel  | ports                                  | handshake
// request  | start, busy, req_item                  | taken when start && !busy
// response | rsp_valid, rsp_item                    | one-cycle strobe, no stall
// config   | csr_valid, csr_ready, csr_index, csr_wdata | written when valid && ready
//
// one item per cycle sustained; the path from the accepting edge to rsp_valid is:
// front register, queue slot, stage 0, the 20-stage restoring divider
// (10 bits of k, 10 bits of j) and the output register
// flatten items run through the same pipeline so results keep request order
// synchronous reset sets all sizes to 1; size writes settle through registered nx/ny/nz, nxy, nxyz, nxyz2, nxyz3
// the receiver cannot stall, so the queue drains every cycle and busy stays low
module grid_index_linearizer_top import gil_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  gil_req_type      req_item,
   output logic             rsp_valid,
   output gil_rsp_type      rsp_item,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

   gil_geom_type geom;
   logic         f_valid, q_full, q_valid;
   gil_item_type f_item, q_item;

   // front: registers, range check
   gil_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .start      (start && !busy),
      .req_item   (req_item),
      .geom       (geom),
      .item_valid (f_valid),
      .item       (f_item)
   );

   // queue between front and back
   gil_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_valid),
      .push_item (f_item),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_item  (q_item)
   );

   assign busy = q_full;

   // back: arithmetic pipeline
   gil_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_item   (q_item),
      .geom      (geom),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

/* hdl/gil_front.sv */
`timescale 1ns / 1ps
module gil_front import gil_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [DIM_W-1:0] csr_wdata,
   input  logic         start,
   input  gil_req_type  req_item,
   output gil_geom_type geom,
   output logic         item_valid,
   output gil_item_type item
);

   logic [DIM_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   gil_geom_type     geom_ff;
   logic [21:0]      nxy_full;
   logic [31:0]      nxyz_full;
   logic             valid_ff;
   gil_item_type     item_ff, item_in;

   assign csr_ready = 1'b1;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= DIM_W'(1);
         size_y_ff <= DIM_W'(1);
         size_z_ff <= DIM_W'(1);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SIZE_X: size_x_ff <= csr_wdata;
            CSR_SIZE_Y: size_y_ff <= csr_wdata;
            CSR_SIZE_Z: size_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign nxy_full  = 22'(geom_ff.nx) * 22'(geom_ff.ny);
   assign nxyz_full = 32'(geom_ff.nxy) * 32'(geom_ff.nz);

   // derived sizes settle after a write through registered nx/ny/nz, nxy, nxyz, nxyz2, nxyz3
   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.nx    <= DIM_W'(1);
         geom_ff.ny    <= DIM_W'(1);
         geom_ff.nz    <= DIM_W'(1);
         geom_ff.nxy   <= NXY_W'(1);
         geom_ff.nxyz  <= NXYZ_W'(1);
         geom_ff.nxyz2 <= IDX_W'(2);
         geom_ff.nxyz3 <= (IDX_W+1)'(3);
      end else begin
         geom_ff.nx    <= gil_clamp(size_x_ff);
         geom_ff.ny    <= gil_clamp(size_y_ff);
         geom_ff.nz    <= gil_clamp(size_z_ff);
         geom_ff.nxy   <= nxy_full[NXY_W-1:0];
         geom_ff.nxyz  <= nxyz_full[NXYZ_W-1:0];
         geom_ff.nxyz2 <= {geom_ff.nxyz, 1'b0};
         geom_ff.nxyz3 <= {1'b0, geom_ff.nxyz2} + {2'b0, geom_ff.nxyz};
      end
   end

   assign geom = geom_ff;

   // range check
   always_comb begin
      item_in.func = req_item.func;
      item_in.i    = req_item.coord_i;
      item_in.j    = req_item.coord_j;
      item_in.k    = req_item.coord_k;
      item_in.d    = req_item.comp_d;
      item_in.idx  = req_item.linear_index;
      if (req_item.func == FUNC_SPLIT) begin
         item_in.err = (geom_ff.nxyz == '0) ||
                       ({1'b0, req_item.linear_index} >= geom_ff.nxyz3);
      end else begin
         item_in.err = ({1'b0, req_item.coord_i} >= geom_ff.nx) ||
                       ({1'b0, req_item.coord_j} >= geom_ff.ny) ||
                       ({1'b0, req_item.coord_k} >= geom_ff.nz) ||
                       (req_item.comp_d == COMP_BAD);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* hdl/gil_queue.sv */
`timescale 1ns / 1ps
module gil_queue import gil_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  gil_item_type push_item,
   output logic         full,
   output logic         pop_valid,
   output gil_item_type pop_item
);

   gil_item_type mem_ff [0:1];
   logic         wp_ff, rp_ff;
   logic [1:0]   cnt_ff;
   logic         pop;

   // drains one item per cycle whenever non-empty
   assign pop       = (cnt_ff != 2'd0);
   assign pop_valid = pop;
   assign pop_item  = mem_ff[rp_ff];
   assign full      = (cnt_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= push_item;
      end
   end

endmodule

/* hdl/gil_back.sv */
`timescale 1ns / 1ps
module gil_back import gil_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  gil_item_type in_item,
   input  gil_geom_type geom,
   output logic         rsp_valid,
   output gil_rsp_type  rsp_item
);

   localparam int STEPS = 2 * COORD_W;

   typedef struct packed {
      logic               func;
      logic               err;
      logic [COORD_W-1:0] i;
      logic [NXY_W-1:0]   pj;
      logic [NXYZ_W-1:0]  pk;
      logic [IDX_W-1:0]   pd;
      logic [1:0]         d;
      logic [NXYZ_W-1:0]  rem;
   } gil_s0_type;

   typedef struct packed {
      logic               func;
      logic               err;
      logic [1:0]         d;
      logic [COORD_W-1:0] k;
      logic [COORD_W-1:0] j;
      logic [NXYZ_W-1:0]  rem;
      logic [IDX_W-1:0]   lin;
   } gil_stage_type;

   gil_s0_type    s0_ff, s0_in;
   gil_stage_type pipe_ff   [1:STEPS];
   gil_stage_type stage_in  [1:STEPS];
   gil_stage_type stage_out [1:STEPS];
   logic [STEPS:0] vld_ff;
   logic [IDX_W-1:0] sub;
   logic          rsp_valid_ff;
   gil_rsp_type   rsp_ff, rsp_in;

   // stage 0: products for flatten, component split for split
   always_comb begin
      s0_in.func = in_item.func;
      s0_in.err  = in_item.err;
      s0_in.i    = in_item.i;
      s0_in.pj   = NXY_W'(in_item.j) * NXY_W'(geom.nx);
      s0_in.pk   = NXYZ_W'(in_item.k) * NXYZ_W'(geom.nxy);
      s0_in.pd   = IDX_W'(in_item.d) * IDX_W'(geom.nxyz);
      if (in_item.idx >= geom.nxyz2) begin
         s0_in.d = 2'd2;
         sub     = geom.nxyz2;
      end else if (in_item.idx >= {1'b0, geom.nxyz}) begin
         s0_in.d = 2'd1;
         sub     = {1'b0, geom.nxyz};
      end else begin
         s0_in.d = 2'd0;
         sub     = '0;
      end
      s0_in.rem = NXYZ_W'(in_item.idx - sub);
   end

   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
   end

   // restoring division, one quotient bit per stage: k bits then j bits
   always_comb begin
      logic [IDX_W-1:0] dv;
      logic [IDX_W-1:0] rx;
      int b;
      stage_in[1].func = s0_ff.func;
      stage_in[1].err  = s0_ff.err;
      stage_in[1].d    = s0_ff.d;
      stage_in[1].k    = '0;
      stage_in[1].j    = '0;
      stage_in[1].rem  = s0_ff.rem;
      stage_in[1].lin  = IDX_W'(s0_ff.i) + IDX_W'(s0_ff.pj) + IDX_W'(s0_ff.pk) + s0_ff.pd;
      for (int s = 2; s <= STEPS; s++) begin
         stage_in[s] = pipe_ff[s-1];
      end
      for (int s = 1; s <= STEPS; s++) begin
         stage_out[s] = stage_in[s];
         rx = IDX_W'(stage_in[s].rem);
         if (s <= COORD_W) begin
            b  = COORD_W - s;
            dv = IDX_W'(geom.nxy) << b;
         end else begin
            b  = STEPS - s;
            dv = IDX_W'(geom.nx) << b;
         end
         if (stage_in[s].func == FUNC_SPLIT && !stage_in[s].err && rx >= dv) begin
            stage_out[s].rem = NXYZ_W'(rx - dv);
            if (s <= COORD_W) stage_out[s].k[b] = 1'b1;
            else              stage_out[s].j[b] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 1; s <= STEPS; s++) begin
         pipe_ff[s] <= stage_out[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= {vld_ff[STEPS-1:0], in_valid};
         rsp_valid_ff <= vld_ff[STEPS];
      end
   end

   // result formatting
   always_comb begin
      rsp_in = '0;
      if (pipe_ff[STEPS].err) begin
         rsp_in.range_error = 1'b1;
      end else if (pipe_ff[STEPS].func == FUNC_SPLIT) begin
         rsp_in.out_i = pipe_ff[STEPS].rem[COORD_W-1:0];
         rsp_in.out_j = pipe_ff[STEPS].j;
         rsp_in.out_k = pipe_ff[STEPS].k;
         rsp_in.out_d = pipe_ff[STEPS].d;
      end else begin
         rsp_in.linear_out = pipe_ff[STEPS].lin;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.range_error |->
         rsp_item.linear_out == '0 && rsp_item.out_i == '0 &&
         rsp_item.out_j == '0 && rsp_item.out_k == '0 && rsp_item.out_d == '0)
      else $error("error result carries nonzero fields");

   a_comp_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.out_d != COMP_BAD)
      else $error("split produced invalid component");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(vld_ff[STEPS]))
      else $error("result strobe without pipeline item");

endmodule
